@@ rtl/jthc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jthc_pkg;

    localparam logic [63:0] MIX_K1     = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_K2     = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] ODD_MUL    = 64'h000000009e3779b9;
    localparam logic [63:0] EVEN_MUL   = 64'h00000000045d9f3b;
    localparam logic [63:0] CHAIN_INIT = 64'd5381;
    localparam logic [29:0] NS_WRAP    = 30'd1000000000;
    localparam logic [29:0] SAMPLE_MAX = 30'd999999999;
    localparam logic [46:0] ROUND_BIAS = 47'd127;
    localparam logic [5:0]  ROT_HI     = 6'd47;
    localparam logic [5:0]  ROT_LO     = 6'd17;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] CFG_MIN_DELAY  = 2'd0;
    localparam logic [1:0] CFG_PART_DELAY = 2'd1;
    localparam logic [1:0] CFG_TIME_SHIFT = 2'd2;
    localparam logic [1:0] CFG_ROUNDS     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_STATS,
        S_THR,
        S_MIX0,
        S_MIX1,
        S_MIX2,
        S_SCR0,
        S_SCR1,
        S_FOLD0,
        S_FOLD1,
        S_FOLD2,
        S_MUL,
        S_OUT
    } state_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] amt);
        logic [127:0] t;
        t = {v, v} << amt;
        return t[127:64];
    endfunction

    // 5 + 2*v, wrapped to a 64-bit rotate amount
    function automatic logic [5:0] odd_rot(input logic [4:0] v);
        return 6'd5 + {v, 1'b0};
    endfunction

endpackage

`default_nettype wire

@@ rtl/jitter_timing_hash_conditioner.sv @@
// Requests: a timestamp sample that finishes a hash leaves its result in the output register.
// Throughput: one request at a time; the 64-bit multiplies run on one shared 32x32
// multiplier, and up to six of them fall on one sample.
// Reset: rst_n clears the sequencer, the statistics and the chained hash to their
// initial values; configuration returns to min_delay 0, part_delay 0, time_shift 0, rounds 1.
`timescale 1ns / 1ps
`default_nettype none

module jitter_timing_hash_conditioner (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [63:0] seed_word,
    input  wire logic [29:0] time_sample,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      hash_word
);

    jthc_pkg::state_t state_reg, state_next;
    jthc_pkg::state_t ret_reg, ret_next;

    logic [19:0] min_delay_reg;
    logic [15:0] part_delay_reg;
    logic [4:0]  time_shift_reg;
    logic [7:0]  rounds_reg;

    logic [63:0] chain_reg, chain_next;
    logic [63:0] work_reg, work_next;
    logic [29:0] prev_reg, prev_next;
    logic [63:0] ent_reg, ent_next;
    logic [29:0] min_reg, min_next;
    logic [29:0] max_reg, max_next;
    logic [63:0] dsum_reg, dsum_next;
    logic [7:0]  exc_reg, exc_next;
    logic [7:0]  rl_reg, rl_next;
    logic        busy_reg, busy_next;
    logic        scr_ent_reg, scr_ent_next;
    logic        fold_chain_reg, fold_chain_next;
    logic [1:0]  mcnt_reg, mcnt_next;
    logic        out_valid_reg, out_valid_next;

    logic [29:0] ts_reg, ts_next;
    logic [29:0] dlt_reg, dlt_next;
    logic [29:0] dff_reg, dff_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] mulb_reg, mulb_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] hash_reg, hash_next;

    logic        accept;
    logic [29:0] ts_sat;
    logic [29:0] dlt_calc;
    logic [38:0] part_term;
    logic [39:0] thr;
    logic        is_exc;
    logic [63:0] fold_p;
    logic [63:0] x_rot;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [2:0]  mix_sh;
    logic [63:0] x_fin;
    logic        out_free;

    assign in_ready  = (state_reg == jthc_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign hash_word = hash_reg;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign ts_sat   = (time_sample > jthc_pkg::SAMPLE_MAX) ? jthc_pkg::SAMPLE_MAX : time_sample;
    assign dlt_calc = (ts_reg < prev_reg) ? (jthc_pkg::NS_WRAP - prev_reg + ts_reg)
                                          : (ts_reg - prev_reg);

    // x_reg holds min_delta * part_delay on entry to S_THR
    assign part_term = (part_delay_reg != 16'd0)
                     ? 39'(({1'b0, x_reg[45:0]} + jthc_pkg::ROUND_BIAS) >> 8)
                     : 39'd1;
    assign thr    = {20'd0, min_delay_reg} + {1'b0, part_term} + {32'd0, exc_reg};
    assign is_exc = ({10'd0, dff_reg} < thr);

    assign fold_p = fold_chain_reg ? chain_reg : {34'd0, prev_reg};
    assign x_rot  = jthc_pkg::rotl64(x_reg, jthc_pkg::odd_rot(x_reg[4:0]));
    assign x_fin  = x_reg ^ jthc_pkg::rotl64(x_reg, x_reg[1] ? jthc_pkg::ROT_HI
                                                             : jthc_pkg::ROT_LO);

    assign mul_a  = (mcnt_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b  = (mcnt_reg == 2'd1) ? mulb_reg[63:32] : mulb_reg[31:0];
    assign mix_sh = ent_reg[0] ? (ent_reg[1] ? 3'd6 : 3'd4) : 3'd5;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jthc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == jthc_pkg::OP_START && rounds_reg == 8'd0)
                        state_next = jthc_pkg::S_OUT;
                    else if (operation == jthc_pkg::OP_SAMPLE && busy_reg)
                        state_next = jthc_pkg::S_DELTA;
                end
            end
            jthc_pkg::S_DELTA:
            begin
                if (prev_reg == 30'd0)
                    state_next = jthc_pkg::S_SCR0;
                else if (dlt_calc == 30'd0)
                    state_next = jthc_pkg::S_IDLE;
                else
                    state_next = jthc_pkg::S_STATS;
            end
            jthc_pkg::S_STATS: state_next = jthc_pkg::S_MUL;
            jthc_pkg::S_THR:
            begin
                if (!is_exc && exc_reg != 8'd0)
                    state_next = jthc_pkg::S_FOLD0;
                else
                    state_next = jthc_pkg::S_MIX0;
            end
            jthc_pkg::S_MIX0:  state_next = jthc_pkg::S_SCR0;
            jthc_pkg::S_SCR0:  state_next = jthc_pkg::S_MUL;
            jthc_pkg::S_SCR1:  state_next = scr_ent_reg ? jthc_pkg::S_MIX1 : jthc_pkg::S_IDLE;
            jthc_pkg::S_MIX1:  state_next = jthc_pkg::S_MIX2;
            jthc_pkg::S_MIX2:
            begin
                if (exc_reg == 8'd0 && rl_reg == 8'd1)
                    state_next = jthc_pkg::S_FOLD0;
                else
                    state_next = jthc_pkg::S_IDLE;
            end
            jthc_pkg::S_FOLD0: state_next = jthc_pkg::S_MUL;
            jthc_pkg::S_FOLD1: state_next = jthc_pkg::S_MUL;
            jthc_pkg::S_FOLD2: state_next = fold_chain_reg ? jthc_pkg::S_OUT : jthc_pkg::S_MIX0;
            jthc_pkg::S_MUL:
            begin
                if (mcnt_reg == 2'd3)
                    state_next = ret_reg;
            end
            jthc_pkg::S_OUT:
            begin
                if (out_free)
                    state_next = jthc_pkg::S_IDLE;
            end
            default: state_next = jthc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        chain_next      = chain_reg;
        work_next       = work_reg;
        prev_next       = prev_reg;
        ent_next        = ent_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        dsum_next       = dsum_reg;
        exc_next        = exc_reg;
        rl_next         = rl_reg;
        busy_next       = busy_reg;
        scr_ent_next    = scr_ent_reg;
        fold_chain_next = fold_chain_reg;
        mcnt_next       = mcnt_reg;
        ret_next        = ret_reg;
        ts_next         = ts_reg;
        dlt_next        = dlt_reg;
        dff_next        = dff_reg;
        x_next          = x_reg;
        mulb_next       = mulb_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        hash_next       = hash_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (state_reg)
            jthc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ts_next = ts_sat >> time_shift_reg;
                    case (operation)
                        jthc_pkg::OP_START:
                        begin
                            if (rounds_reg == 8'd0)
                            begin
                                x_next = 64'd0;
                            end
                            else
                            begin
                                work_next = chain_reg ^ seed_word;
                                rl_next   = rounds_reg;
                                prev_next = 30'd0;
                                ent_next  = 64'd0;
                                exc_next  = 8'd0;
                                busy_next = 1'b1;
                            end
                        end
                        jthc_pkg::OP_CLEAR:
                        begin
                            min_next = jthc_pkg::NS_WRAP;
                            max_next = 30'd0;
                        end
                        default: ;
                    endcase
                end
            end
            jthc_pkg::S_DELTA:
            begin
                dlt_next = dlt_calc;
                if (prev_reg == 30'd0)
                begin
                    // first sample of this hash: seed prev and stir the work hash
                    prev_next    = ts_reg;
                    x_next       = work_reg ^ {34'd0, ts_reg};
                    scr_ent_next = 1'b0;
                end
            end
            jthc_pkg::S_STATS:
            begin
                dsum_next = dsum_reg + {34'd0, dlt_reg};
                if (dlt_reg < min_reg)
                begin
                    dff_next = min_reg - dlt_reg;
                    min_next = dlt_reg;
                    ent_next = ent_reg ^ (64'd0 - {34'd0, min_reg - dlt_reg})
                             ^ {34'd0, dlt_reg};
                    x_next   = {34'd0, dlt_reg};
                end
                else if (dlt_reg > max_reg)
                begin
                    dff_next = dlt_reg - min_reg;
                    max_next = dlt_reg;
                    ent_next = ent_reg ^ {34'd0, dlt_reg - min_reg}
                             ^ (64'd0 - {34'd0, dlt_reg});
                    x_next   = {34'd0, min_reg};
                end
                else
                begin
                    dff_next = dlt_reg - min_reg;
                    ent_next = ent_reg ^ ~{34'd0, dlt_reg - min_reg} ^ {34'd0, max_reg};
                    x_next   = {34'd0, min_reg};
                end
                mulb_next = {48'd0, part_delay_reg};
                ret_next  = jthc_pkg::S_THR;
            end
            jthc_pkg::S_THR:
            begin
                if (is_exc)
                begin
                    exc_next = exc_reg + 8'd4;
                end
                else
                begin
                    dsum_next       = dsum_reg + {34'd0, dlt_reg};
                    exc_next        = 8'd0;
                    fold_chain_next = 1'b0;
                end
            end
            jthc_pkg::S_MIX0:
            begin
                x_next = ent_reg ^ ({34'd0, ts_reg} << 13) ^ ({34'd0, dlt_reg} << 7)
                       ^ dsum_reg;
                scr_ent_next = 1'b1;
            end
            jthc_pkg::S_SCR0:
            begin
                x_next    = x_rot;
                mulb_next = x_rot[0] ? jthc_pkg::ODD_MUL : jthc_pkg::EVEN_MUL;
                ret_next  = jthc_pkg::S_SCR1;
            end
            jthc_pkg::S_SCR1:
            begin
                if (scr_ent_reg)
                    ent_next = x_fin;
                else
                    work_next = x_fin;
            end
            jthc_pkg::S_MIX1:
            begin
                ent_next  = ent_reg >> 2;
                work_next = (work_reg << mix_sh)
                          + (ent_reg[1] ? (64'd0 - work_reg) : work_reg);
            end
            jthc_pkg::S_MIX2:
            begin
                work_next = jthc_pkg::rotl64(work_reg ^ ((ent_reg >> 5) << 3),
                                             jthc_pkg::odd_rot(ent_reg[4:0]));
                if (exc_reg == 8'd0)
                begin
                    rl_next = rl_reg - 8'd1;
                    if (rl_reg == 8'd1)
                    begin
                        busy_next       = 1'b0;
                        fold_chain_next = 1'b1;
                    end
                    else
                    begin
                        prev_next = ts_reg;
                    end
                end
            end
            jthc_pkg::S_FOLD0:
            begin
                x_next    = fold_p ^ (work_reg >> 29);
                mulb_next = jthc_pkg::MIX_K1;
                ret_next  = jthc_pkg::S_FOLD1;
            end
            jthc_pkg::S_FOLD1:
            begin
                x_next    = x_reg ^ (x_reg >> 31);
                mulb_next = jthc_pkg::MIX_K2;
                ret_next  = jthc_pkg::S_FOLD2;
            end
            jthc_pkg::S_FOLD2:
            begin
                x_next = x_reg ^ (x_reg >> 33) ^ (fold_p << 33);
                if (fold_chain_reg)
                    chain_next = x_reg ^ (x_reg >> 33) ^ (fold_p << 33);
                else
                    work_next = x_reg ^ (x_reg >> 33) ^ (fold_p << 33);
            end
            jthc_pkg::S_MUL:
            begin
                // low 64 bits of x * mulb from three 32x32 partial products
                prod_next = {32'd0, mul_a} * {32'd0, mul_b};
                mcnt_next = mcnt_reg + 2'd1;
                case (mcnt_reg)
                    2'd1:    acc_next = prod_reg;
                    2'd2:    acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                    2'd3:    x_next   = acc_reg + {prod_reg[31:0], 32'd0};
                    default: ;
                endcase
            end
            jthc_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    hash_next      = x_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= jthc_pkg::S_IDLE;
            ret_reg        <= jthc_pkg::S_IDLE;
            min_delay_reg  <= 20'd0;
            part_delay_reg <= 16'd0;
            time_shift_reg <= 5'd0;
            rounds_reg     <= 8'd1;
            chain_reg      <= jthc_pkg::CHAIN_INIT;
            work_reg       <= 64'd0;
            prev_reg       <= 30'd0;
            ent_reg        <= 64'd0;
            min_reg        <= jthc_pkg::NS_WRAP;
            max_reg        <= 30'd0;
            dsum_reg       <= 64'd0;
            exc_reg        <= 8'd0;
            rl_reg         <= 8'd0;
            busy_reg       <= 1'b0;
            scr_ent_reg    <= 1'b0;
            fold_chain_reg <= 1'b0;
            mcnt_reg       <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            chain_reg      <= chain_next;
            work_reg       <= work_next;
            prev_reg       <= prev_next;
            ent_reg        <= ent_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            dsum_reg       <= dsum_next;
            exc_reg        <= exc_next;
            rl_reg         <= rl_next;
            busy_reg       <= busy_next;
            scr_ent_reg    <= scr_ent_next;
            fold_chain_reg <= fold_chain_next;
            mcnt_reg       <= mcnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    jthc_pkg::CFG_MIN_DELAY:  min_delay_reg  <= cfg_data;
                    jthc_pkg::CFG_PART_DELAY: part_delay_reg <= cfg_data[15:0];
                    jthc_pkg::CFG_TIME_SHIFT: time_shift_reg <= cfg_data[4:0];
                    jthc_pkg::CFG_ROUNDS:     rounds_reg     <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg   <= ts_next;
        dlt_reg  <= dlt_next;
        dff_reg  <= dff_next;
        x_reg    <= x_next;
        mulb_reg <= mulb_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        hash_reg <= hash_next;
    end

    a_mcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != jthc_pkg::S_MUL) |-> (mcnt_reg == 2'd0))
        else $error("multiply step counter left running");

    a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
        min_reg <= jthc_pkg::NS_WRAP)
        else $error("minimum delta out of range");

    a_prev_range: assert property (@(posedge clk) disable iff (!rst_n)
        prev_reg <= jthc_pkg::SAMPLE_MAX)
        else $error("previous sample out of range");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == jthc_pkg::OP_START && rounds_reg != 8'd0)
        |=> (busy_reg && rl_reg != 8'd0))
        else $error("start request did not arm the round counter");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jthc_pkg::S_OUT && out_free) |=> out_valid_reg)
        else $error("result not loaded into the output register");

endmodule

`default_nettype wire
